// File: design/mic4_pkg.sv
// ----------------------------------------------------------------------------
// mic4_pkg
// shared types and constants of the multichannel fourth-order iir filter
// ----------------------------------------------------------------------------
package mic4_pkg;

  localparam int COEF_W         = 32;
  localparam int COEF_FRAC      = 28;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = 3;
  localparam int CH_FIELD_W     = 3;
  localparam int SAMPLE_FIELD_W = 32;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd4;

  // numerator taps b1..b3, denominator taps a1..a4
  localparam int NUM_B_TAPS = 3;
  localparam int NUM_A_TAPS = 4;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_RESET [NUM_REGS] = '{
    32'sd0,
    32'sd6798828,
    -32'sd13598466,
    32'sd6799629,
    -32'sd984038662,
    32'sd1350539588,
    -32'sd822380612,
    32'sd187447739
  };

  // multiplier operand source
  typedef enum logic [1:0] {
    SRC_X,
    SRC_XH,
    SRC_YH
  } mul_src_e;

  typedef struct packed {
    logic     clear;
    logic     mul_en;
    mul_src_e src;
  } mac_ctl_t;

endpackage

// File: design/multichannel_iir_order4.sv
// ----------------------------------------------------------------------------
// multichannel_iir_order4
// multichannel direct-form-i iir filter with one shared coefficient set,
// histories kept in two memories and one multiply-accumulate unit
// ----------------------------------------------------------------------------
//  channel | direction | signals                                | beat
//  in      | sink      | in_valid_i/in_ready_o                  | channel, sample
//  out     | source    | out_valid_o/out_ready_i                | channel, result
//  cfg     | sink      | cfg_we_i, cfg_idx_i, cfg_wdata_i       | one coefficient
//
//  an item steps from accept to the result register with the single multiplier
//  doing one product a cycle.
//  a channel out of range skips the multiply steps and reaches the result
//  register with a zero result.
//  reset clears coefficients to defaults; history entries read zero until
//  written, so there is no clearing pass.
//  a result waiting on out_ready_i holds only the final write-back; the next
//  beat is accepted as soon as the result is registered.
// ----------------------------------------------------------------------------
module multichannel_iir_order4 #(
  parameter int CHANNELS    = 6,
  parameter int ORDER       = 4,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mic4_pkg::CH_FIELD_W-1:0]       channel_i,
  input  logic [mic4_pkg::SAMPLE_FIELD_W-1:0]   sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [mic4_pkg::CH_FIELD_W-1:0]       channel_out_o,
  output logic [mic4_pkg::SAMPLE_FIELD_W-1:0]   sample_out_o,
  input  logic                                  cfg_we_i,
  input  logic [mic4_pkg::REG_IDX_W-1:0]        cfg_idx_i,
  input  logic [mic4_pkg::COEF_W-1:0]           cfg_wdata_i
);
  import mic4_pkg::*;

  localparam int DEPTH  = CHANNELS * ORDER;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int CNT_W  = $clog2(2 * ORDER + 5);
  localparam int S2_W   = $clog2(2 * ORDER + 1) + 1;

  localparam logic [CNT_W-1:0] RD_LAST   = CNT_W'(2 * ORDER);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(2 * ORDER + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2 * ORDER + 3);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          ch_ok_q;
  logic [CH_FIELD_W-1:0]         ch_q;
  logic [ADDR_W-1:0]             base_q;
  logic [SLOT_W-1:0]             ptr_cur_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [SLOT_W-1:0]             ptr_q [CHANNELS];
  coef_t                         coef_q [NUM_REGS];
  logic                          out_valid_q, out_valid_d;
  logic [CH_FIELD_W-1:0]         channel_out_q;
  logic [SAMPLE_FIELD_W-1:0]     sample_out_q, sample_out_d;

  logic                          in_fire;
  logic                          fin_fire;
  logic                          ch_ok_in;
  logic [CH_W-1:0]               ch_idx_in;
  logic [CNT_W-1:0]              mul_tap;
  logic [CNT_W-1:0]              rd_tap;
  logic [S2_W-1:0]               rd_sum;
  logic [S2_W-1:0]               rd_slot;
  logic [ADDR_W-1:0]             rd_addr;
  logic [SLOT_W-1:0]             wr_slot;
  logic [ADDR_W-1:0]             wr_addr;
  logic                          wr_en;
  mac_ctl_t                      mac_ctl;
  coef_t                         mac_coef;
  logic [SAMPLE_BITS-1:0]        xh_rd;
  logic [SAMPLE_BITS-1:0]        yh_rd;
  logic signed [SAMPLE_BITS-1:0] y_res;

  // handshake
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fin_fire   = (state_q == ST_RUN) && (cnt_q == LAST_STEP) &&
                      (!out_valid_q || out_ready_i);
  assign ch_ok_in   = (int'(channel_i) < CHANNELS);
  assign ch_idx_in  = CH_W'(channel_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    if (in_fire) begin
      state_d = ST_RUN;
      cnt_d   = ch_ok_in ? '0 : LAST_STEP;
    end else if (fin_fire) begin
      state_d = ST_IDLE;
    end else if ((state_q == ST_RUN) && (cnt_q != LAST_STEP)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_ok_q   <= ch_ok_in;
      ch_q      <= channel_i;
      base_q    <= ADDR_W'(ch_idx_in * ORDER);
      ptr_cur_q <= ptr_q[ch_idx_in];
      x_q       <= sample_in_i[SAMPLE_BITS-1:0];
    end
  end

  // per-channel ring pointer, slot of the newest sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_q[i] <= '0;
      end
    end else if (wr_en) begin
      ptr_q[CH_W'(ch_q)] <= wr_slot;
    end
  end

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // history read, tap k sits k-1 slots behind the pointer
  assign rd_tap  = (cnt_q + CNT_W'(1)) >> 1;
  assign rd_sum  = S2_W'(ptr_cur_q) + S2_W'(ORDER) - S2_W'(rd_tap - CNT_W'(1));
  assign rd_slot = (rd_sum >= S2_W'(ORDER)) ? (rd_sum - S2_W'(ORDER)) : rd_sum;
  assign rd_addr = base_q + ADDR_W'(rd_slot);

  // write-back overwrites the oldest slot
  assign wr_slot = (ptr_cur_q == SLOT_W'(ORDER - 1)) ? '0 : (ptr_cur_q + SLOT_W'(1));
  assign wr_addr = base_q + ADDR_W'(wr_slot);
  assign wr_en   = fin_fire && ch_ok_q;

  // multiply step: x first, then b_k*x[n-k] and a_k*y[n-k] in turn
  assign mul_tap = cnt_q >> 1;

  always_comb begin
    mac_ctl.clear  = in_fire;
    mac_ctl.mul_en = (state_q == ST_RUN) && (cnt_q >= CNT_W'(1)) && (cnt_q <= MUL_LAST);
    if (cnt_q == CNT_W'(1)) begin
      mac_ctl.src = SRC_X;
    end else if (!cnt_q[0]) begin
      mac_ctl.src = SRC_XH;
    end else begin
      mac_ctl.src = SRC_YH;
    end
  end

  always_comb begin
    mac_coef = '0;
    case (mac_ctl.src)
      SRC_X: begin
        mac_coef = coef_q[REG_B0];
      end
      SRC_XH: begin
        if (mul_tap <= CNT_W'(NUM_B_TAPS)) begin
          mac_coef = coef_q[REG_IDX_W'(mul_tap)];
        end
      end
      SRC_YH: begin
        if ((mul_tap >= CNT_W'(1)) && (mul_tap <= CNT_W'(NUM_A_TAPS))) begin
          mac_coef = coef_q[REG_A1 + REG_IDX_W'(mul_tap - CNT_W'(1))];
        end
      end
      default: begin
        mac_coef = '0;
      end
    endcase
  end

  mic4_hist_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_xhist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (x_q),
    .raddr_i (rd_addr),
    .rdata_o (xh_rd)
  );

  mic4_hist_mem #(
    .DEPTH  (DEPTH),
    .WIDTH  (SAMPLE_BITS),
    .ADDR_W (ADDR_W)
  ) u_yhist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (y_res),
    .raddr_i (rd_addr),
    .rdata_o (yh_rd)
  );

  mic4_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ORDER       (ORDER)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .coef_i (mac_coef),
    .x_i    (x_q),
    .xh_i   (xh_rd),
    .yh_i   (yh_rd),
    .y_o    (y_res)
  );

  // output register
  assign sample_out_d = ch_ok_q ? SAMPLE_FIELD_W'(y_res) : '0;

  always_comb begin
    out_valid_d = out_valid_q;
    if (fin_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      channel_out_q <= ch_q;
      sample_out_q  <= sample_out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = channel_out_q;
  assign sample_out_o  = sample_out_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= LAST_STEP))
    else $error("step counter past last step");

  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && ch_ok_q && (cnt_q >= CNT_W'(1)) && (cnt_q <= RD_LAST))
      |-> ((rd_addr >= base_q) && (int'(rd_addr) < int'(base_q) + ORDER)))
    else $error("history read outside the channel's rows");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && ch_ok_q) |-> (int'(ptr_cur_q) < ORDER))
    else $error("ring pointer out of range");

  a_bad_ch_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !ch_ok_in) |=> ((cnt_q == LAST_STEP) && !mac_ctl.mul_en))
    else $error("out-of-range channel entered the multiply sequence");
`endif

endmodule

// File: design/mic4_hist_mem.sv
// ----------------------------------------------------------------------------
// mic4_hist_mem
// sample history memory, one write and one registered read per cycle;
// entries never written read as zero
// ----------------------------------------------------------------------------
module mic4_hist_mem #(
  parameter int DEPTH  = 24,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

// File: design/mic4_mac.sv
// ----------------------------------------------------------------------------
// mic4_mac
// shared multiplier, wide accumulator and output truncation with saturation
// ----------------------------------------------------------------------------
module mic4_mac #(
  parameter int SAMPLE_BITS = 32,
  parameter int ORDER       = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mic4_pkg::mac_ctl_t            ctl_i,
  input  mic4_pkg::coef_t               coef_i,
  input  logic signed [SAMPLE_BITS-1:0] x_i,
  input  logic signed [SAMPLE_BITS-1:0] xh_i,
  input  logic signed [SAMPLE_BITS-1:0] yh_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);
  import mic4_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + $clog2(2 * ORDER + 1) + 1;

  localparam logic signed [SUM_W-1:0] YMAX =
    {{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] YMIN = ~YMAX;

  logic signed [SAMPLE_BITS-1:0] opnd;
  logic signed [PROD_W-1:0]      prod_d;
  logic signed [PROD_W-1:0]      prod_q;
  logic                          prod_vld_q;
  logic                          prod_neg_q;
  logic signed [SUM_W-1:0]       prod_ext;
  logic signed [SUM_W-1:0]       acc_d;
  logic signed [SUM_W-1:0]       acc_q;
  logic signed [SUM_W-1:0]       acc_sh;

  always_comb begin
    case (ctl_i.src)
      SRC_X:   opnd = x_i;
      SRC_XH:  opnd = xh_i;
      SRC_YH:  opnd = yh_i;
      default: opnd = '0;
    endcase
  end

  assign prod_d = coef_i * opnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    prod_neg_q <= (ctl_i.src == SRC_YH);
    acc_q      <= acc_d;
  end

  assign prod_ext = {{(SUM_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = prod_neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end else begin
      acc_d = acc_q;
    end
  end

  // floor to q15.16, then clamp
  assign acc_sh = acc_q >>> COEF_FRAC;

  always_comb begin
    if (acc_sh > YMAX) begin
      y_o = YMAX[SAMPLE_BITS-1:0];
    end else if (acc_sh < YMIN) begin
      y_o = YMIN[SAMPLE_BITS-1:0];
    end else begin
      y_o = acc_sh[SAMPLE_BITS-1:0];
    end
  end

`ifndef SYNTH
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |-> !prod_vld_q)
    else $error("accumulator cleared while a product is pending");
`endif

endmodule

// File: tb/iir_result_check.sv
// ----------------------------------------------------------------------------
// iir_result_check
// watches the sample and result channels of the multichannel fourth-order
// iir filter, follows coefficient writes, predicts every filtered sample
// from its own copy of the channel histories and compares each result beat
// in order against it
// ----------------------------------------------------------------------------
module iir_result_check #(
  parameter int CHANNELS = 6,
  parameter int ORDER    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic [mic4_pkg::CH_FIELD_W-1:0]     channel_i,
  input  logic [mic4_pkg::SAMPLE_FIELD_W-1:0] sample_in_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic [mic4_pkg::CH_FIELD_W-1:0]     channel_out_i,
  input  logic [mic4_pkg::SAMPLE_FIELD_W-1:0] sample_out_i,
  input  logic                                cfg_we_i,
  input  logic [mic4_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mic4_pkg::COEF_W-1:0]         cfg_wdata_i,
  output int                                  pending_o,
  output int                                  errors_o
);
  import mic4_pkg::*;

  localparam int ACC_W = 72;

  typedef logic signed [SAMPLE_FIELD_W-1:0] smp_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [CH_FIELD_W-1:0] ch;
    smp_t                  y;
  } filtered_t;

  localparam acc_t Y_MAX = {{(ACC_W-SAMPLE_FIELD_W+1){1'b0}}, {(SAMPLE_FIELD_W-1){1'b1}}};
  localparam acc_t Y_MIN = ~Y_MAX;

  coef_t     coef_q [NUM_REGS];
  smp_t      x_hist [CHANNELS][ORDER];
  smp_t      y_hist [CHANNELS][ORDER];
  filtered_t filtered_q [$];
  int        mismatches;

  function automatic smp_t filter_sample(int ch, smp_t x);
    acc_t acc;
    acc_t y_wide;
    smp_t y;
    acc = coef_q[REG_B0] * x;
    for (int k = 1; k <= NUM_B_TAPS; k++) acc += coef_q[REG_B0 + k] * x_hist[ch][k-1];
    for (int k = 1; k <= NUM_A_TAPS; k++) acc -= coef_q[REG_A1 + k - 1] * y_hist[ch][k-1];
    // arithmetic shift drops the coefficient fraction, rounding toward minus infinity
    y_wide = acc >>> COEF_FRAC;
    if (y_wide > Y_MAX) y = Y_MAX[SAMPLE_FIELD_W-1:0];
    else if (y_wide < Y_MIN) y = Y_MIN[SAMPLE_FIELD_W-1:0];
    else y = y_wide[SAMPLE_FIELD_W-1:0];
    for (int k = ORDER - 1; k >= 1; k--) begin
      x_hist[ch][k] = x_hist[ch][k-1];
      y_hist[ch][k] = y_hist[ch][k-1];
    end
    x_hist[ch][0] = x;
    y_hist[ch][0] = y;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filtered_t e;
    if (!rst_ni) begin
      coef_q = COEF_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < ORDER; k++) begin
          x_hist[c][k] = '0;
          y_hist[c][k] = '0;
        end
      end
      filtered_q.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_we_i) coef_q[cfg_idx_i] = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: channel %0d sample %0d",
                   $time, channel_out_i, $signed(sample_out_i));
          mismatches++;
        end else begin
          e = filtered_q.pop_front();
          if (channel_out_i !== e.ch) begin
            $display("%0t: channel_out expected %0d got %0d", $time, e.ch, channel_out_i);
            mismatches++;
          end
          if (sample_out_i !== e.y) begin
            $display("%0t: channel %0d sample_out expected %0d got %0d",
                     $time, e.ch, e.y, $signed(sample_out_i));
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        e.ch = channel_i;
        // a channel out of range leaves the histories alone
        if (channel_i < CHANNELS) e.y = filter_sample(channel_i, sample_in_i);
        else e.y = '0;
        filtered_q.push_back(e);
      end
      pending_o <= filtered_q.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// File: tb/multichannel_iir_order4_tb.sv
// ----------------------------------------------------------------------------
// multichannel_iir_order4_tb
// drives samples and coefficient sets into the multichannel iir filter:
// directed extremes and saturation, then random phases under several
// coefficient settings and idle patterns; results are checked beside it
// ----------------------------------------------------------------------------
module multichannel_iir_order4_tb;
  import mic4_pkg::*;

  localparam int CHANNELS      = 6;
  localparam int ORDER         = 4;
  localparam int LATENCY       = 2 * ORDER + 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS   = 53;

  localparam logic [SAMPLE_FIELD_W-1:0] S_MAX = 32'h7fff_ffff;
  localparam logic [SAMPLE_FIELD_W-1:0] S_MIN = 32'h8000_0000;
  localparam coef_t C_MAX = 32'sh7fff_ffff;
  localparam coef_t C_MIN = 32'sh8000_0000;

  typedef coef_t coef_set_t [NUM_REGS];

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic [CH_FIELD_W-1:0]     channel_i   = '0;
  logic [SAMPLE_FIELD_W-1:0] sample_in_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [CH_FIELD_W-1:0]     channel_out_o;
  logic [SAMPLE_FIELD_W-1:0] sample_out_o;
  logic                      cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0]      cfg_idx_i   = '0;
  logic [COEF_W-1:0]         cfg_wdata_i = '0;

  int pending;
  int mismatches;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  multichannel_iir_order4 #(
    .CHANNELS   (CHANNELS),
    .ORDER      (ORDER),
    .SAMPLE_BITS(32)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .channel_out_o(channel_out_o),
    .sample_out_o (sample_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  iir_result_check #(
    .CHANNELS(CHANNELS),
    .ORDER   (ORDER)
  ) u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .channel_i    (channel_i),
    .sample_in_i  (sample_in_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .channel_out_i(channel_out_o),
    .sample_out_i (sample_out_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .errors_o     (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_sample(input logic [CH_FIELD_W-1:0] ch,
                             input logic [SAMPLE_FIELD_W-1:0] x);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    sample_in_i <= x;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_filter_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic load_coefs(input coef_set_t c);
    cfg_we_i <= 1'b1;
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_idx_i   <= REG_IDX_W'(i);
      cfg_wdata_i <= c[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SAMPLE_FIELD_W-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return 32'($urandom_range(32'h001f_ffff)) - 32'h0010_0000;
      4, 5, 6:    return $urandom();
      default: begin
        case ($urandom_range(4))
          0:       return S_MAX;
          1:       return S_MIN;
          2:       return '0;
          3:       return '1;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CH_FIELD_W-1:0] pick_channel();
    if ($urandom_range(12) == 0) return CH_FIELD_W'($urandom_range(7, CHANNELS));
    return CH_FIELD_W'($urandom_range(CHANNELS - 1));
  endfunction

  function automatic coef_set_t pick_coefs(int kind);
    coef_set_t c;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (kind)
        0: c[i] = COEF_RESET[i];
        1: c[i] = coef_t'($urandom_range(32'h07ff_ffff)) - 32'sh0400_0000;
        2: c[i] = $urandom();
        default: begin
          case ($urandom_range(4))
            0:       c[i] = C_MAX;
            1:       c[i] = C_MIN;
            2:       c[i] = '0;
            3:       c[i] = '1;
            default: c[i] = 32'sh1000_0000;
          endcase
        end
      endcase
    end
    return c;
  endfunction

  // receiver, with a long hold-off counted here on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    coef_set_t c;
    int        kind;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients, field extremes, channels out of range
    send_sample(3'd0, '0);
    send_sample(3'd0, S_MAX);
    send_sample(3'd0, S_MIN);
    send_sample(3'd1, 32'h0001_0000);
    send_sample(3'd1, '1);
    send_sample(3'd5, S_MAX);
    send_sample(3'd5, S_MAX);
    send_sample(3'd6, S_MAX);
    send_sample(3'd7, S_MIN);
    send_sample(3'd2, 32'h0000_0001);
    wait_filter_idle();

    // full-scale b taps push the sum past both ends
    c = '{C_MAX, C_MIN, C_MAX, C_MIN, '0, '0, '0, '0};
    load_coefs(c);
    send_sample(3'd3, S_MAX);
    send_sample(3'd3, S_MIN);
    send_sample(3'd3, S_MAX);
    send_sample(3'd4, 32'h0000_0001);
    send_sample(3'd4, S_MIN);
    wait_filter_idle();

    c = '{C_MIN, '0, '0, '0, C_MAX, C_MIN, C_MAX, C_MIN};
    load_coefs(c);
    send_sample(3'd2, S_MAX);
    send_sample(3'd2, S_MIN);
    send_sample(3'd2, '0);
    send_sample(3'd2, '0);
    send_sample(3'd2, '1);
    send_sample(3'd0, S_MIN);
    send_sample(3'd7, '1);
    wait_filter_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      kind = (p < 4) ? p : $urandom_range(3);
      load_coefs(pick_coefs(kind));
      case (p % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 49; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 49; end
        default: begin send_gap_pct = 34; recv_stall_pct = 34; end
      endcase
      if (p == 2 || p == 9) hold_request = LONG_HOLD;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_channel(), pick_sample());
      wait_filter_idle();
    end

    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: multichannel_iir_order4.f
design/mic4_pkg.sv
design/mic4_hist_mem.sv
design/mic4_mac.sv
design/multichannel_iir_order4.sv
tb/iir_result_check.sv
tb/multichannel_iir_order4_tb.sv
